// ===== hdl/tspp_pkg.sv =====
// ----------------------------------------------------------------------------
// tspp_pkg
// Shared types, constants and helpers of the timed setpoint schedule player.
// ----------------------------------------------------------------------------
package tspp_pkg;

  // schedule geometry
  localparam int unsigned SchedDepth = 64;
  localparam int unsigned IdxW       = (SchedDepth > 1) ? $clog2(SchedDepth) : 1;
  localparam int unsigned PtrW       = $clog2(SchedDepth + 1);

  localparam logic [31:0]        EndMark        = 32'hFFFF_FFFF;
  localparam logic [7:0]         CollapseLenCm  = 8'd1;
  localparam logic signed [19:0] DegPerCmQ4     = -20'sd1216;  // -76 deg in q.4

  typedef enum logic [1:0] {
    CmdTick     = 2'd0,
    CmdStart    = 2'd1,
    CmdCollapse = 2'd2,
    CmdLoad     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] time_value;
    logic        motor_select;
    logic [5:0]  entry_index;
    logic [7:0]  entry_length;
  } in_beat_t;

  typedef struct packed {
    logic               motor;
    logic [7:0]         length_cm;
    logic signed [19:0] goal_position;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] time_value;
    logic [7:0]  len_cm;
  } sched_entry_t;

  typedef struct packed {
    logic               en;
    logic [IdxW-1:0]    addr;
    sched_entry_t       entry;
  } sched_wr_t;

  // goal angle = length * -76 deg + zero offset, all in q.4
  function automatic logic signed [19:0] goal_f(input logic [7:0] len_cm,
                                                input logic signed [16:0] offset);
    logic signed [19:0] len_s;
    logic signed [19:0] off_s;
    len_s = signed'({12'd0, len_cm});
    off_s = signed'({{3{offset[16]}}, offset});
    return 20'(len_s * DegPerCmQ4) + off_s;
  endfunction

endpackage

// ===== hdl/tspp_sched_mem.sv =====
// ----------------------------------------------------------------------------
// tspp_sched_mem
// One motor's schedule: one write port, one registered read port with
// write-to-read bypass on a same-address access.
// ----------------------------------------------------------------------------
module tspp_sched_mem (
  input  logic                              clk_i,
  input  tspp_pkg::sched_wr_t               wr_i,
  input  logic [tspp_pkg::IdxW-1:0]         rd_addr_i,
  output tspp_pkg::sched_entry_t            rd_data_o
);

  tspp_pkg::sched_entry_t mem_q [tspp_pkg::SchedDepth];
  tspp_pkg::sched_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
  end

  // new data wins when the entry being written is the one being read
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == rd_addr_i)) begin
      rd_q <= wr_i.entry;
    end else begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hdl/timed_setpoint_schedule_player_unit.sv =====
// ----------------------------------------------------------------------------
// timed_setpoint_schedule_player_unit
// Plays two per-motor (time, length) schedules and emits motor goal angles.
// ----------------------------------------------------------------------------
// A command beat enters an input register and is executed from there against
// the current state once the result register can take its results (none, one
// or two); they land in a two-slot result register and leave one beat per
// cycle while out_ready_i is high. Loads, starts and ticks that fire no entry
// are taken at one beat per cycle, ticks that fire one entry too while the
// output is not stalled; a collapse or a tick that fires both motors keeps the
// result register busy until both beats have left, so the sustained rate is set
// by the number of result beats (one per cycle). Each motor's schedule lives in
// its own memory with one read and one write port; the entry at each play
// pointer is prefetched every cycle (read at the next pointer value, with bypass
// of a load to the same place), so a tick needs no separate memory read. There
// is no clearing pass after reset: reading an entry that was never loaded is not
// allowed. A pointer that reaches the schedule depth counts as end of schedule.
// ----------------------------------------------------------------------------
module timed_setpoint_schedule_player_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command beats
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tspp_pkg::in_beat_t  in_data_i,
  // goal beats
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tspp_pkg::out_beat_t out_data_o,
  // zero offset registers
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [16:0]         cfg_wdata_i
);

  localparam logic CfgOffsetFirst  = 1'b0;
  localparam logic CfgOffsetSecond = 1'b1;

  // configuration
  logic signed [16:0] off0_q, off1_q;

  // input register
  logic               in_valid_q, in_valid_d;
  tspp_pkg::in_beat_t in_q;

  // playback state
  logic [31:0]                start_q, start_d;
  logic                       running_q, running_d;
  logic [tspp_pkg::PtrW-1:0]  ptr0_q, ptr0_d, ptr1_q, ptr1_d;

  // schedule heads
  tspp_pkg::sched_entry_t head0, head1;
  tspp_pkg::sched_wr_t    wr0, wr1;

  // result register: two slots, sel_q picks the one on the port
  logic                out_valid_q, out_valid_d;
  logic                sel_q, sel_d;
  tspp_pkg::out_beat_t r0_q, r0_d, r1_q, r1_d;

  // execute-stage signals
  logic                fire;
  logic                is_tick, is_collapse;
  logic [31:0]         elapsed;
  logic                due0, due1, take0, take1, has_res, two_res;
  logic [7:0]          len0, len1;
  tspp_pkg::out_beat_t e0, e1;
  logic                out_last, res_free, load_ok;

  // --------------------------------------------------------------------------
  // configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off0_q <= '0;
      off1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgOffsetFirst:  off0_q <= signed'(cfg_wdata_i);
        CfgOffsetSecond: off1_q <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // schedule memories, read at the next pointer so the head is ready
  // --------------------------------------------------------------------------
  tspp_sched_mem u_sched0 (
    .clk_i     (clk_i),
    .wr_i      (wr0),
    .rd_addr_i (tspp_pkg::IdxW'(ptr0_d)),
    .rd_data_o (head0)
  );

  tspp_sched_mem u_sched1 (
    .clk_i     (clk_i),
    .wr_i      (wr1),
    .rd_addr_i (tspp_pkg::IdxW'(ptr1_d)),
    .rd_data_o (head1)
  );

  // --------------------------------------------------------------------------
  // execute: decide what the registered command does this cycle
  // --------------------------------------------------------------------------
  always_comb begin
    is_tick     = (in_q.command == tspp_pkg::CmdTick);
    is_collapse = (in_q.command == tspp_pkg::CmdCollapse);
    elapsed     = in_q.time_value - start_q;

    // an entry fires when it is not the end mark and its time has come
    due0 = in_valid_q && is_tick && running_q
        && (32'(ptr0_q) < 32'(tspp_pkg::SchedDepth))
        && (head0.time_value != tspp_pkg::EndMark)
        && (head0.time_value <= elapsed);
    due1 = in_valid_q && is_tick && running_q
        && (32'(ptr1_q) < 32'(tspp_pkg::SchedDepth))
        && (head1.time_value != tspp_pkg::EndMark)
        && (head1.time_value <= elapsed);

    take0   = due0 || (in_valid_q && is_collapse);
    take1   = due1 || (in_valid_q && is_collapse);
    has_res = take0 || take1;
    two_res = take0 && take1;

    len0 = is_collapse ? tspp_pkg::CollapseLenCm : head0.len_cm;
    len1 = is_collapse ? tspp_pkg::CollapseLenCm : head1.len_cm;

    e0.motor         = 1'b0;
    e0.length_cm     = len0;
    e0.goal_position = tspp_pkg::goal_f(len0, off0_q);
    e0.last          = !two_res;
    e1.motor         = 1'b1;
    e1.length_cm     = len1;
    e1.goal_position = tspp_pkg::goal_f(len1, off1_q);
    e1.last          = 1'b1;

    // commands with no result never wait for the output side
    out_last = sel_q || r0_q.last;
    res_free = !out_valid_q || (out_ready_i && out_last);
    fire     = in_valid_q && (!has_res || res_free);

    load_ok = (32'(in_q.entry_index) < 32'(tspp_pkg::SchedDepth));
  end

  // load writes
  always_comb begin
    wr0.en    = fire && (in_q.command == tspp_pkg::CmdLoad) && load_ok
             && !in_q.motor_select;
    wr1.en    = fire && (in_q.command == tspp_pkg::CmdLoad) && load_ok
             && in_q.motor_select;
    wr0.addr  = tspp_pkg::IdxW'(in_q.entry_index);
    wr1.addr  = tspp_pkg::IdxW'(in_q.entry_index);
    wr0.entry = '{time_value: in_q.time_value, len_cm: in_q.entry_length};
    wr1.entry = '{time_value: in_q.time_value, len_cm: in_q.entry_length};
  end

  // playback state next values
  always_comb begin
    start_d   = start_q;
    running_d = running_q;
    ptr0_d    = ptr0_q;
    ptr1_d    = ptr1_q;
    if (fire) begin
      case (in_q.command)
        tspp_pkg::CmdTick: begin
          ptr0_d = ptr0_q + tspp_pkg::PtrW'(due0);
          ptr1_d = ptr1_q + tspp_pkg::PtrW'(due1);
        end
        tspp_pkg::CmdStart: begin
          start_d   = in_q.time_value;
          running_d = 1'b1;
          ptr0_d    = '0;
          ptr1_d    = '0;
        end
        tspp_pkg::CmdCollapse: begin
          running_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      running_q <= 1'b0;
      ptr0_q    <= '0;
      ptr1_q    <= '0;
    end else begin
      start_q   <= start_d;
      running_q <= running_d;
      ptr0_q    <= ptr0_d;
      ptr1_q    <= ptr1_d;
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  assign in_ready_o = !in_valid_q || fire;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // result register, first slot then second
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    if (fire && has_res) begin
      out_valid_d = 1'b1;
      sel_d       = 1'b0;
      r0_d        = take0 ? e0 : e1;
      r1_d        = e1;
    end else if (out_valid_q && out_ready_i) begin
      if (out_last) begin
        out_valid_d = 1'b0;
      end else begin
        sel_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = sel_q ? r1_q : r0_q;

endmodule
